[hw/rtl/prf_pkg.sv]
// Shared types and constants of the pcap record framer.
package prf_pkg;

    // Command codes on the input channel
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // Kinds of output run built for one input transaction
    localparam logic [1:0] KIND_GLOBAL = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;

    // Configuration register indexes (paddr[2])
    localparam logic REG_SNAP_LENGTH = 1'b0;
    localparam logic REG_LINK_TYPE   = 1'b1;

    localparam int          PADDR_W      = 3;
    localparam logic [31:0] PCAP_MAGIC   = 32'ha1b2c3d4;
    localparam logic [15:0] SNAP_RESET   = 16'd256;
    localparam logic [31:0] LINK_RESET   = 32'd105;
    localparam logic [15:0] NO_FRAME     = 16'hFFFF;
    localparam logic [15:0] VER_MAJOR    = 16'd2;
    localparam logic [15:0] VER_MINOR    = 16'd4;
    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

    // 1e6 = 64 * 15625; floor(2^32 / 15625) gives a quotient estimate that
    // is exact or one low for any 26-bit dividend.
    localparam logic [18:0] RECIP_15625  = 19'd274877;

    localparam int RUN_BYTES = 24;
    localparam int RUN_W     = RUN_BYTES * 8;

    typedef struct packed {
        logic [1:0]  kind;
        logic        has_data;
        logic [7:0]  data;
        logic [15:0] incl;
        logic [15:0] flen;
        logic [31:0] rel;
        logic [31:0] frames;
        logic [31:0] bytes;
    } prf_item_t;

endpackage

[hw/rtl/prf_ingress.sv]
// Command decode, session state and the input register of the framer.
module prf_ingress (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic                adv,
    input  logic [1:0]          cmd,
    input  logic [7:0]          data_byte,
    input  logic                first_of_frame,
    input  logic [15:0]         frame_length,
    input  logic [31:0]         timestamp_us,
    input  logic [15:0]         snap_length,
    output logic                item_valid,
    output prf_pkg::prf_item_t  item
);
    import prf_pkg::*;

    logic        capturing_reg, capturing_next;
    logic [31:0] base_time_reg, base_time_next;
    logic [15:0] byte_position_reg, byte_position_next;
    logic [31:0] frame_counter_reg, frame_counter_next;
    logic [31:0] byte_counter_reg, byte_counter_next;
    logic        item_valid_reg;
    prf_item_t   item_reg, item_next;
    logic        emit;
    logic [15:0] incl;
    logic [15:0] pos_eff;
    logic        keep;

    assign incl    = (frame_length < snap_length) ? frame_length : snap_length;
    assign pos_eff = first_of_frame ? 16'd0 : byte_position_reg;
    assign keep    = pos_eff < incl;

    always_comb begin
        capturing_next     = capturing_reg;
        base_time_next     = base_time_reg;
        byte_position_next = byte_position_reg;
        frame_counter_next = frame_counter_reg;
        byte_counter_next  = byte_counter_reg;
        emit               = 1'b0;
        item_next.kind     = KIND_DATA;
        item_next.has_data = 1'b0;
        case (cmd)
            CMD_START: begin
                if (!capturing_reg) begin
                    capturing_next     = 1'b1;
                    base_time_next     = timestamp_us;
                    byte_position_next = NO_FRAME;
                    frame_counter_next = 32'd0;
                    byte_counter_next  = 32'd0;
                    emit               = 1'b1;
                    item_next.kind     = KIND_GLOBAL;
                end
            end
            CMD_STOP: begin
                capturing_next = 1'b0;
            end
            CMD_BYTE: begin
                if (capturing_reg) begin
                    if (first_of_frame) begin
                        frame_counter_next = frame_counter_reg + 32'd1;
                        byte_counter_next  = byte_counter_reg + 32'd16 + {16'd0, incl};
                    end
                    byte_position_next = keep ? pos_eff + 16'd1 : pos_eff;
                    emit               = first_of_frame | keep;
                    item_next.kind     = first_of_frame ? KIND_RECORD : KIND_DATA;
                    item_next.has_data = keep;
                end
            end
            default: ;
        endcase
        item_next.data   = data_byte;
        item_next.incl   = incl;
        item_next.flen   = frame_length;
        item_next.rel    = timestamp_us - base_time_reg;
        item_next.frames = frame_counter_next;
        item_next.bytes  = byte_counter_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capturing_reg     <= 1'b0;
            base_time_reg     <= 32'd0;
            byte_position_reg <= 16'd0;
            frame_counter_reg <= 32'd0;
            byte_counter_reg  <= 32'd0;
            item_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                capturing_reg     <= capturing_next;
                base_time_reg     <= base_time_next;
                byte_position_reg <= byte_position_next;
                frame_counter_reg <= frame_counter_next;
                byte_counter_reg  <= byte_counter_next;
            end
            if (adv) begin
                item_valid_reg <= accept & emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

[hw/rtl/prf_time_split.sv]
// Two multiply stages that estimate seconds of the relative capture time.
module prf_time_split (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  prf_pkg::prf_item_t  in_item,
    output logic                out_valid,
    output prf_pkg::prf_item_t  out_item,
    output logic [12:0]         q_est,
    output logic [31:0]         qm
);
    import prf_pkg::*;

    logic        b_valid_reg;
    prf_item_t   b_item_reg;
    logic [44:0] prod_reg;
    logic        c_valid_reg;
    prf_item_t   c_item_reg;
    logic [12:0] q_est_reg;
    logic [31:0] qm_reg;
    logic [12:0] q_raw;
    logic [32:0] qm_full;

    // rel / 1e6 == (rel >> 6) / 15625
    assign q_raw   = prod_reg[44:32];
    assign qm_full = q_raw * USEC_PER_SEC;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= in_valid;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_item_reg <= in_item;
            prod_reg   <= in_item.rel[31:6] * RECIP_15625;
            c_item_reg <= b_item_reg;
            q_est_reg  <= q_raw;
            qm_reg     <= qm_full[31:0];
        end
    end

    assign out_valid = c_valid_reg;
    assign out_item  = c_item_reg;
    assign q_est     = q_est_reg;
    assign qm        = qm_reg;

endmodule

[hw/rtl/prf_serializer.sv]
// Result register: builds the byte run of one transaction and drains it.
module prf_serializer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  prf_pkg::prf_item_t  in_item,
    input  logic [12:0]         q_est,
    input  logic [31:0]         qm,
    input  logic [15:0]         snap_length,
    input  logic [31:0]         link_type,
    input  logic                m_ready,
    output logic                adv,
    output logic                m_valid,
    output logic [7:0]          m_out_byte,
    output logic                m_last_in_run,
    output logic [31:0]         m_frames_written,
    output logic [31:0]         m_bytes_written
);
    import prf_pkg::*;

    logic               res_valid_reg;
    logic [4:0]         idx_reg;
    logic [4:0]         last_idx_reg, last_idx_next;
    logic [RUN_W-1:0]   run_reg, run_next;
    logic [31:0]        frames_reg;
    logic [31:0]        bytes_reg;
    logic [31:0]        r_full;
    logic [20:0]        r0;
    logic               over;
    logic [12:0]        sec;
    logic [19:0]        usec;
    logic [20:0]        r_sub;

    // Fix the quotient estimate with one compare and subtract
    assign r_full = in_item.rel - qm;
    assign r0     = r_full[20:0];
    assign over   = r0 >= {1'b0, USEC_PER_SEC};
    assign r_sub  = r0 - {1'b0, USEC_PER_SEC};
    assign sec    = over ? q_est + 13'd1 : q_est;
    assign usec   = over ? r_sub[19:0] : r0[19:0];

    always_comb begin
        case (in_item.kind)
            KIND_GLOBAL: begin
                run_next      = {link_type, 16'd0, snap_length, 64'd0,
                                 VER_MINOR, VER_MAJOR, PCAP_MAGIC};
                last_idx_next = 5'd23;
            end
            KIND_RECORD: begin
                run_next      = {56'd0, in_item.data, 16'd0, in_item.flen,
                                 16'd0, in_item.incl, 12'd0, usec, 19'd0, sec};
                last_idx_next = in_item.has_data ? 5'd16 : 5'd15;
            end
            KIND_DATA: begin
                run_next      = {{(RUN_W-8){1'b0}}, in_item.data};
                last_idx_next = 5'd0;
            end
            default: begin
                run_next      = '0;
                last_idx_next = 5'd0;
            end
        endcase
    end

    assign m_last_in_run = idx_reg == last_idx_reg;
    assign adv           = !res_valid_reg || (m_ready && m_last_in_run);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
            idx_reg       <= 5'd0;
        end else if (adv) begin
            res_valid_reg <= in_valid;
            idx_reg       <= 5'd0;
        end else if (m_ready) begin
            idx_reg <= idx_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            run_reg      <= run_next;
            last_idx_reg <= last_idx_next;
            frames_reg   <= in_item.frames;
            bytes_reg    <= in_item.bytes;
        end
    end

    assign m_valid          = res_valid_reg;
    assign m_out_byte       = run_reg[{idx_reg, 3'b000} +: 8];
    assign m_frames_written = frames_reg;
    assign m_bytes_written  = bytes_reg;

endmodule

[hw/rtl/pcap_record_framer.sv]
// Top level of the pcap record framer: APB registers and the framing pipeline.
//
// The framer turns a capture session into a little-endian pcap byte stream,
// one byte per output transaction. A start command (taken only while no session
// is open) latches the base time, clears the frame and byte counters and sends
// the 24-byte global header. A frame byte flagged as first of frame sends the
// 16-byte record header (seconds and microseconds since start, included length,
// original length) and then, as every frame byte does, its data byte as long as
// fewer than min(frame_length, snap_length) bytes of the frame have passed.
// Stop closes the session; commands that make no bytes vanish silently.
// Every byte of a run carries the counter values after its transaction, and
// m_last_in_run marks the run's final byte. Rate: a transaction producing
// N bytes holds the output until all N bytes are taken (1 for a data byte,
// 16 or 17 for a frame start, 24 for a start), and an input transaction is
// taken in any cycle in which the result register is empty or the last byte
// of its run is taken, so a stream of data bytes moves at one per cycle
// while m_ready stays high. The one-byte-per-cycle output serializer sets
// this figure. From input to the first byte an item passes the input
// register, two multiply stages that split the microsecond time by 1e6, and
// the result register. Registers: snap_length at byte address 0 (reset 256),
// link_type at 4 (reset 105); write them only while the block is idle.
module pcap_record_framer (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_cmd,
    input  logic [7:0]                  s_data_byte,
    input  logic                        s_first_of_frame,
    input  logic [15:0]                 s_frame_length,
    input  logic [31:0]                 s_timestamp_us,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_out_byte,
    output logic                        m_last_in_run,
    output logic [31:0]                 m_frames_written,
    output logic [31:0]                 m_bytes_written,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [prf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import prf_pkg::*;

    logic [15:0] snap_length_reg;
    logic [31:0] link_type_reg;
    logic        cfg_write;
    logic        adv;
    logic        accept;
    logic        a_valid;
    prf_item_t   a_item;
    logic        c_valid;
    prf_item_t   c_item;
    logic [12:0] q_est;
    logic [31:0] qm;

    // Register block: write on the access phase, word select by paddr[2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_length_reg <= SNAP_RESET;
            link_type_reg   <= LINK_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_SNAP_LENGTH) begin
                snap_length_reg <= pwdata[15:0];
            end else begin
                link_type_reg <= pwdata;
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_LINK_TYPE) begin
            prdata = link_type_reg;
        end else begin
            prdata = {16'd0, snap_length_reg};
        end
    end

    // The whole pipeline advances together; hold it while a run drains
    assign s_ready = adv;
    assign accept  = s_valid && s_ready;

    prf_ingress u_ingress (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .adv            (adv),
        .cmd            (s_cmd),
        .data_byte      (s_data_byte),
        .first_of_frame (s_first_of_frame),
        .frame_length   (s_frame_length),
        .timestamp_us   (s_timestamp_us),
        .snap_length    (snap_length_reg),
        .item_valid     (a_valid),
        .item           (a_item)
    );

    prf_time_split u_time_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (a_valid),
        .in_item   (a_item),
        .out_valid (c_valid),
        .out_item  (c_item),
        .q_est     (q_est),
        .qm        (qm)
    );

    prf_serializer u_serializer (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (c_valid),
        .in_item          (c_item),
        .q_est            (q_est),
        .qm               (qm),
        .snap_length      (snap_length_reg),
        .link_type        (link_type_reg),
        .m_ready          (m_ready),
        .adv              (adv),
        .m_valid          (m_valid),
        .m_out_byte       (m_out_byte),
        .m_last_in_run    (m_last_in_run),
        .m_frames_written (m_frames_written),
        .m_bytes_written  (m_bytes_written)
    );

endmodule

[hw/rtl/prf_checker.sv]
// Port-level checks of the pcap record framer and their bind.
module prf_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [7:0]                  m_out_byte,
    input logic                        m_last_in_run,
    input logic [31:0]                 m_frames_written,
    input logic [31:0]                 m_bytes_written
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_last_in_run))
        else $error("stalled result changed");

    // A run continues without a gap and with the same counters
    a_run_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_in_run |=> m_valid
            && $stable(m_frames_written) && $stable(m_bytes_written))
        else $error("run broken or counters moved inside a run");

    // With no pending result the input side is open
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind pcap_record_framer prf_checker u_prf_checker (.*);
